@@ design/fmsp_pkg.sv @@
// fmsp_pkg: types and constants for the file mode string parser.
// Shared by fmsp_decode and file_mode_string_parser; depends on nothing.
package fmsp_pkg;

   // Parse phase, one-hot
   typedef enum logic [7:0] {
      PH_START = 8'b0000_0001,
      PH_OCTAL = 8'b0000_0010,
      PH_WHO   = 8'b0000_0100,
      PH_OPER  = 8'b0000_1000,
      PH_COPY  = 8'b0001_0000,
      PH_PERM  = 8'b0010_0000,
      PH_DONE  = 8'b0100_0000,
      PH_ERROR = 8'b1000_0000
   } phase_type;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_SET = 2'd2
   } op_type;

   localparam int MODE_W = 16;
   localparam int PERM_W = 12;
   localparam int MASK_W = 9;
   localparam int CHAR_W = 8;

   localparam logic [PERM_W-1:0] PERM_ALL      = 12'o7777;
   localparam logic [MODE_W-1:0] TYPE_MASK     = 16'hF000;
   localparam logic [MODE_W-1:0] TYPE_DIR      = 16'h4000;
   localparam logic [MODE_W-1:0] OVERFLOW_MODE = 16'o0775;
   localparam logic [MASK_W-1:0] MASK_RESET    = 9'd18;

   // who letter bit sets
   localparam logic [MODE_W-1:0] WHO_ALL   = 16'o6777;
   localparam logic [MODE_W-1:0] WHO_USER  = 16'o4700;
   localparam logic [MODE_W-1:0] WHO_GROUP = 16'o2070;
   localparam logic [MODE_W-1:0] WHO_OTHER = 16'o0007;

   // permission letter bit sets
   localparam logic [PERM_W-1:0] PERM_R = 12'o0444;
   localparam logic [PERM_W-1:0] PERM_W_BITS = 12'o0222;
   localparam logic [PERM_W-1:0] PERM_X = 12'o0111;
   localparam logic [PERM_W-1:0] PERM_S = 12'o6000;
   localparam logic [PERM_W-1:0] PERM_T = 12'o1000;

   // character codes
   localparam logic [CHAR_W-1:0] CHR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHR_0     = 8'h30;
   localparam logic [CHAR_W-1:0] CHR_7     = 8'h37;
   localparam logic [CHAR_W-1:0] CHR_LC_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CHR_LC_U  = 8'h75;
   localparam logic [CHAR_W-1:0] CHR_LC_G  = 8'h67;
   localparam logic [CHAR_W-1:0] CHR_LC_O  = 8'h6F;
   localparam logic [CHAR_W-1:0] CHR_LC_R  = 8'h72;
   localparam logic [CHAR_W-1:0] CHR_LC_W  = 8'h77;
   localparam logic [CHAR_W-1:0] CHR_LC_X  = 8'h78;
   localparam logic [CHAR_W-1:0] CHR_UC_X  = 8'h58;
   localparam logic [CHAR_W-1:0] CHR_LC_S  = 8'h73;
   localparam logic [CHAR_W-1:0] CHR_LC_T  = 8'h74;
   localparam logic [CHAR_W-1:0] CHR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHR_EQUAL = 8'h3D;
   localparam logic [CHAR_W-1:0] CHR_COMMA = 8'h2C;

   typedef struct packed {
      phase_type           phase;
      logic [MODE_W-1:0]   working_mode;
      logic [MODE_W-1:0]   who_bits;
      logic [PERM_W-1:0]   perm_bits;
      logic [PERM_W-1:0]   clear_bits;
      op_type              operator_code;
      logic [PERM_W-1:0]   octal_value;
      logic                octal_overflow;
   } parse_state_type;

   typedef struct packed {
      logic                valid;
      logic [MODE_W-1:0]   mode_out;
      logic                parse_error;
   } parse_result_type;

endpackage

@@ design/file_mode_string_parser.sv @@
// An end-of-string beat's result is registered in the output register, or in
// the skid entry while the output is stalled. Throughput: one beat per cycle;
// the state registers close the loop, and the two-entry output keeps the input
// open while one result waits. req_stall rises only when both entries are full.
// Reset (synchronous, active high): parser at start phase, working mode zero,
// output empty, creation mask back to 0022.
module file_mode_string_parser (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [15:0] req_mode_in,
   input  logic [7:0]  req_char_code,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_mode_out,
   output logic        rsp_parse_error,
   // configuration
   input  logic        csr_write_enable,
   input  logic [8:0]  csr_write_data
);
   import fmsp_pkg::*;

   // creation mask register
   logic [MASK_W-1:0] creation_mask_ff;

   // parser state
   parse_state_type   state_ff;
   parse_state_type   state_in;
   parse_result_type  result;

   // output register and skid entry
   logic              out_valid_ff, out_valid_in;
   logic [MODE_W-1:0] out_mode_ff, out_mode_in;
   logic              out_error_ff, out_error_in;
   logic              skid_valid_ff, skid_valid_in;
   logic [MODE_W-1:0] skid_mode_ff, skid_mode_in;
   logic              skid_error_ff, skid_error_in;

   logic              req_beat;
   logic              new_result;
   logic              out_free;

   assign req_beat   = req_valid && !skid_valid_ff;
   assign new_result = req_beat && result.valid;
   // output register can take data this cycle
   assign out_free   = !out_valid_ff || !rsp_stall;

   fmsp_decode u_decode (
      .state         (state_ff),
      .action        (req_action),
      .mode_in       (req_mode_in),
      .char_code     (req_char_code),
      .creation_mask (creation_mask_ff),
      .next_state    (state_in),
      .result        (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         creation_mask_ff <= MASK_RESET;
      end else if (csr_write_enable) begin
         creation_mask_ff <= csr_write_data;
      end
   end

   // state advances on every accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{phase: PH_START, working_mode: '0, who_bits: '0, perm_bits: '0,
                       clear_bits: '0, operator_code: OP_ADD, octal_value: '0,
                       octal_overflow: 1'b0};
      end else if (req_beat) begin
         state_ff <= state_in;
      end
   end

   // output queue: skid drains first; while it is full no beat is taken
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_mode_in   = out_mode_ff;
      out_error_in  = out_error_ff;
      skid_valid_in = skid_valid_ff;
      skid_mode_in  = skid_mode_ff;
      skid_error_in = skid_error_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_mode_in   = skid_mode_ff;
            out_error_in  = skid_error_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = new_result;
            out_mode_in  = result.mode_out;
            out_error_in = result.parse_error;
         end
      end else if (new_result) begin
         skid_valid_in = 1'b1;
         skid_mode_in  = result.mode_out;
         skid_error_in = result.parse_error;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_mode_ff   <= out_mode_in;
      out_error_ff  <= out_error_in;
      skid_mode_ff  <= skid_mode_in;
      skid_error_ff <= skid_error_in;
   end

   assign req_stall       = skid_valid_ff;
   assign rsp_valid       = out_valid_ff;
   assign rsp_mode_out    = out_mode_ff;
   assign rsp_parse_error = out_error_ff;

endmodule

@@ design/fmsp_decode.sv @@
// fmsp_decode: next parser state and result for one input beat.
// Pure combinational; uses fmsp_pkg types and constants.
module fmsp_decode (
   input  fmsp_pkg::parse_state_type  state,
   input  logic                       action,
   input  logic [15:0]                mode_in,
   input  logic [7:0]                 char_code,
   input  logic [8:0]                 creation_mask,
   output fmsp_pkg::parse_state_type  next_state,
   output fmsp_pkg::parse_result_type result
);
   import fmsp_pkg::*;

   logic              digit;
   logic [14:0]       octal_acc;
   logic              sym_go;
   logic              in_perm;
   phase_type         sym_phase;
   logic [MODE_W-1:0] sel;
   logic [2:0]        triplet;

   assign digit     = (char_code >= CHR_0) && (char_code <= CHR_7);
   assign octal_acc = {state.octal_value, 3'b000} + {12'd0, char_code[2:0]};

   always_comb begin
      next_state = state;
      sym_go     = 1'b0;
      sym_phase  = state.phase;
      in_perm    = 1'b0;
      sel        = '0;
      triplet    = '0;

      // top-level phase handling
      if (!action) begin
         next_state               = '0;
         next_state.phase         = PH_START;
         next_state.working_mode  = mode_in;
         next_state.operator_code = OP_ADD;
      end else if (char_code != CHR_NUL) begin
         unique case (state.phase)
            PH_START: begin
               if (digit) begin
                  next_state.octal_value = {9'd0, char_code[2:0]};
                  next_state.phase       = PH_OCTAL;
               end else begin
                  sym_go           = 1'b1;
                  sym_phase        = PH_WHO;
                  next_state.phase = PH_WHO;
               end
            end
            PH_OCTAL: begin
               if (!digit) begin
                  next_state.phase = PH_ERROR;
               end else if (!state.octal_overflow) begin
                  if (octal_acc > {3'd0, PERM_ALL})
                     next_state.octal_overflow = 1'b1;
                  else
                     next_state.octal_value = octal_acc[PERM_W-1:0];
               end
            end
            PH_WHO, PH_COPY, PH_PERM: sym_go = 1'b1;
            default: ;
         endcase
      end else begin
         unique case (state.phase)
            PH_START, PH_OCTAL: begin
               if (state.octal_overflow)
                  next_state.working_mode = OVERFLOW_MODE;
               else
                  next_state.working_mode = ({4'd0, state.octal_value}
                     | (state.working_mode & TYPE_MASK)) & ~{7'd0, creation_mask};
               next_state.phase = PH_DONE;
            end
            PH_WHO:           next_state.phase = PH_ERROR;
            PH_COPY, PH_PERM: sym_go = 1'b1;
            default: ;
         endcase
      end

      // clause characters
      if (sym_go) begin
         if (sym_phase == PH_WHO) begin
            unique case (char_code)
               CHR_LC_A: next_state.who_bits = state.who_bits | WHO_ALL;
               CHR_LC_U: next_state.who_bits = state.who_bits | WHO_USER;
               CHR_LC_G: next_state.who_bits = state.who_bits | WHO_GROUP;
               CHR_LC_O: next_state.who_bits = state.who_bits | WHO_OTHER;
               default: begin
                  // empty who list falls back to everything the umask allows
                  if (state.who_bits == '0) begin
                     next_state.clear_bits = PERM_ALL;
                     next_state.who_bits   = ~{7'd0, creation_mask};
                  end else begin
                     next_state.clear_bits = state.who_bits[PERM_W-1:0];
                  end
                  next_state.phase = PH_COPY;
                  unique case (char_code)
                     CHR_PLUS:  next_state.operator_code = OP_ADD;
                     CHR_MINUS: next_state.operator_code = OP_SUB;
                     CHR_EQUAL: next_state.operator_code = OP_SET;
                     default:   next_state.phase = PH_ERROR;
                  endcase
               end
            endcase
         end else begin
            in_perm = (sym_phase == PH_PERM);
            if (sym_phase == PH_COPY) begin
               unique case (char_code)
                  CHR_LC_U: triplet = state.working_mode[8:6];
                  CHR_LC_G: triplet = state.working_mode[5:3];
                  CHR_LC_O: triplet = state.working_mode[2:0];
                  default: begin
                     in_perm          = 1'b1;
                     next_state.phase = PH_PERM;
                  end
               endcase
               next_state.perm_bits = state.perm_bits | {3'd0, triplet, triplet, triplet};
            end
            if (in_perm) begin
               unique case (char_code)
                  CHR_LC_R: next_state.perm_bits = state.perm_bits | PERM_R;
                  CHR_LC_W: next_state.perm_bits = state.perm_bits | PERM_W_BITS;
                  CHR_LC_X: next_state.perm_bits = state.perm_bits | PERM_X;
                  CHR_LC_S: next_state.perm_bits = state.perm_bits | PERM_S;
                  CHR_LC_T: next_state.perm_bits = state.perm_bits | PERM_T;
                  CHR_UC_X: begin
                     if (((state.working_mode & TYPE_MASK) == TYPE_DIR)
                         || ((state.working_mode & {4'd0, PERM_X}) != '0))
                        next_state.perm_bits = state.perm_bits | PERM_X;
                  end
                  default: begin
                     // clause ends: apply it
                     sel = {4'd0, state.perm_bits} & state.who_bits;
                     next_state.working_mode = state.working_mode;
                     if (state.operator_code == OP_SET)
                        next_state.working_mode = next_state.working_mode
                           & ~{4'd0, state.clear_bits};
                     if (state.operator_code == OP_SUB)
                        next_state.working_mode = next_state.working_mode & ~sel;
                     else
                        next_state.working_mode = next_state.working_mode | sel;
                     if (char_code == CHR_COMMA) begin
                        next_state.who_bits  = '0;
                        next_state.perm_bits = '0;
                        next_state.phase     = PH_WHO;
                     end else begin
                        next_state.phase = PH_DONE;
                     end
                  end
               endcase
            end
         end
      end
   end

   assign result.valid       = action && (char_code == CHR_NUL);
   assign result.mode_out    = next_state.working_mode;
   assign result.parse_error = (next_state.phase == PH_ERROR);

endmodule

@@ design/fmsp_checker.sv @@
// fmsp_checker: port-level assertions for file_mode_string_parser.
// Watches top-level ports only; attached by the bind statement below.
module fmsp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_action,
   input logic [7:0]  req_char_code,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_mode_out,
   input logic        rsp_parse_error
);

   logic req_fire;
   logic end_beat;

   assign req_fire = req_valid && !req_stall;
   assign end_beat = req_action && (req_char_code == 8'h00);

   // held result keeps its beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_mode_out)
         && $stable(rsp_parse_error))
      else $error("result beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a beat that ends no string makes no result
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_fire && !end_beat && !rsp_valid |=> !rsp_valid)
      else $error("result without end-of-string beat");

   a_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_fire && end_beat && !rsp_valid |=> rsp_valid)
      else $error("end-of-string beat gave no result");

   // second waiting result fills the skid and closes the input
   a_skid_full: assert property (@(posedge clock) disable iff (reset)
      req_fire && end_beat && rsp_valid && rsp_stall |=> req_stall)
      else $error("input open with two results waiting");

endmodule

bind file_mode_string_parser fmsp_checker u_fmsp_checker (.*);
